// ----- rtl/core/ohl_pkg.sv -----
package ohl_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_HANDLE_BITS = 16;

    // Widths of the broadcast control fields, sized for the largest capacity (256).
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    typedef enum logic [3:0] {
        CMD_INS_FIRST = 4'd0,
        CMD_INS_END   = 4'd1,
        CMD_INS_AT    = 4'd2,
        CMD_REM_FIRST = 4'd3,
        CMD_REM_LAST  = 4'd4,
        CMD_REM_ITEM  = 4'd5,
        CMD_REM_AT    = 4'd6,
        CMD_SEARCH    = 4'd7,
        CMD_GET       = 4'd8,
        CMD_CLEAR     = 4'd9,
        CMD_REVERSE   = 4'd10
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_RANGE     = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } cell_op_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
        logic [CNT_W-1:0] cnt;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/ohl_cell.sv -----
module ohl_cell #(
    parameter int HANDLE_BITS = ohl_pkg::DEF_HANDLE_BITS,
    parameter int INDEX       = 0
) (
    input  logic                      aclk,
    input  ohl_pkg::cell_ctrl_t       ctrl,
    input  logic [HANDLE_BITS-1:0]    ins_data,
    input  logic [HANDLE_BITS-1:0]    key,
    input  logic [HANDLE_BITS-1:0]    left_q,
    input  logic [HANDLE_BITS-1:0]    right_q,
    output logic [HANDLE_BITS-1:0]    q,
    input  logic                      hit_prior_in,
    output logic                      hit_prior_out,
    input  logic [ohl_pkg::IDX_W-1:0] fidx_in,
    output logic [ohl_pkg::IDX_W-1:0] fidx_out,
    input  logic [HANDLE_BITS-1:0]    rd_in,
    output logic [HANDLE_BITS-1:0]    rd_out
);
    import ohl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [HANDLE_BITS-1:0] data_reg;
    logic [HANDLE_BITS-1:0] data_next;
    logic                   in_list;
    logic                   hit;
    logic                   first_hit;

    assign q         = data_reg;
    assign in_list   = CNT_W'(INDEX) < ctrl.cnt;
    assign hit       = in_list && (data_reg == key);
    assign first_hit = hit && !hit_prior_in;

    assign hit_prior_out = hit_prior_in | hit;
    assign fidx_out      = fidx_in | (first_hit ? MY_IDX : '0);
    assign rd_out        = rd_in | ((MY_IDX == ctrl.rd_idx) ? data_reg : '0);

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (MY_IDX == ctrl.wr_idx) begin
                    data_next = ins_data;
                end else if (MY_IDX > ctrl.wr_idx) begin
                    data_next = left_q;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= ctrl.wr_idx) begin
                    data_next = right_q;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ----- rtl/core/ordered_handle_list.sv -----
// Ordered list of up to CAPACITY process handles held in a chain of cells, one entry per
// cell. Inserts shift the cells behind the slot one place back and removes shift them one
// place forward; search and rem_item compare every cell at once and take the match
// nearest the front, and get reads a cell through the chain's read path.
// Every command gives one result item, registered on the m_ side; the next command is
// taken once that register is empty or in the same cycle its result is taken, so a
// result that waits on m_tready holds off the input. Only reverse holds the input off on
// its own: it takes the tail entry and inserts it at slot 0, then at slot 1 and so on,
// one step per cycle and n-1 steps on a list of n entries; its result goes out at once,
// and the input stays stalled in ST_REV until the last step (no stall for n of two or fewer).
module ordered_handle_list #(
    parameter int CAPACITY    = ohl_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = ohl_pkg::DEF_HANDLE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[3:0], position[8:4], handle[24:9], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[2:0], found_position[6:3],
                                   // read_handle[22:7], count[27:23], zeros
);
    import ohl_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_REV  = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [IW-1:0]          k_reg, k_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                res_status_reg, res_status_next;
    logic [3:0]             res_fpos_reg, res_fpos_next;
    logic [15:0]            res_rd_reg, res_rd_next;
    logic [4:0]             res_count_reg, res_count_next;

    cmd_t                   cmd;
    logic [4:0]             pos;
    logic [HANDLE_BITS-1:0] h_in;
    logic [CMPW-1:0]        pos_x;
    logic [CMPW-1:0]        cnt_x;
    logic                   accept;
    logic                   list_full;
    logic                   use_tail;
    logic [IDX_W-1:0]       tail_idx;
    logic [HANDLE_BITS-1:0] ins_data;
    cell_ctrl_t             ctrl;
    cell_op_t               op;
    logic [IDX_W-1:0]       wr_idx;

    logic [HANDLE_BITS-1:0] cell_q     [CAPACITY];
    logic                   hit_chain  [CAPACITY+1];
    logic [IDX_W-1:0]       fidx_chain [CAPACITY+1];
    logic [HANDLE_BITS-1:0] rd_chain   [CAPACITY+1];

    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [HANDLE_BITS-1:0] rd_data;
    logic [HANDLE_BITS+15:0] rd_wide;
    logic [HANDLE_BITS+15:0] h_wide;

    assign cmd    = cmd_t'(s_tdata[3:0]);
    assign pos    = s_tdata[8:4];
    assign h_wide = {{HANDLE_BITS{1'b0}}, s_tdata[24:9]};
    assign h_in   = h_wide[HANDLE_BITS-1:0];
    assign pos_x  = CMPW'(pos);
    assign cnt_x  = CMPW'(count_reg);

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign list_full = count_reg == CW'(CAPACITY);
    assign tail_idx  = IDX_W'(count_reg - 1'b1);

    // Reverse feeds the tail entry back in at the front of the unreversed part.
    assign use_tail = (state_reg == ST_REV) || (cmd == CMD_REVERSE);
    assign ins_data = use_tail ? rd_data : h_in;

    assign ctrl.op     = op;
    assign ctrl.wr_idx = wr_idx;
    assign ctrl.rd_idx = use_tail ? tail_idx : IDX_W'(pos);
    assign ctrl.cnt    = CNT_W'(count_reg);

    assign hit_chain[0]  = 1'b0;
    assign fidx_chain[0] = '0;
    assign rd_chain[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [HANDLE_BITS-1:0] left_q;
            logic [HANDLE_BITS-1:0] right_q;
            if (gi == 0) begin : g_head
                assign left_q = ins_data;
            end else begin : g_body
                assign left_q = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign right_q = cell_q[gi];
            end else begin : g_inner
                assign right_q = cell_q[gi+1];
            end
            ohl_cell #(
                .HANDLE_BITS(HANDLE_BITS),
                .INDEX      (gi)
            ) u_cell (
                .aclk         (aclk),
                .ctrl         (ctrl),
                .ins_data     (ins_data),
                .key          (h_in),
                .left_q       (left_q),
                .right_q      (right_q),
                .q            (cell_q[gi]),
                .hit_prior_in (hit_chain[gi]),
                .hit_prior_out(hit_chain[gi+1]),
                .fidx_in      (fidx_chain[gi]),
                .fidx_out     (fidx_chain[gi+1]),
                .rd_in        (rd_chain[gi]),
                .rd_out       (rd_chain[gi+1])
            );
        end
    endgenerate

    assign any_hit = hit_chain[CAPACITY];
    assign hit_idx = fidx_chain[CAPACITY];
    assign rd_data = rd_chain[CAPACITY];
    assign rd_wide = {16'b0, rd_data};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        res_status_next = res_status_reg;
        res_fpos_next   = res_fpos_reg;
        res_rd_next     = res_rd_reg;
        res_count_next  = res_count_reg;
        op              = CELL_HOLD;
        wr_idx          = '0;

        case (state_reg)
            ST_REV: begin
                op     = CELL_INS;
                wr_idx = IDX_W'(k_reg);
                if (k_reg == IW'(count_reg - CW'(2))) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_status_next = STAT_OK;
                    res_fpos_next   = 4'd0;
                    res_rd_next     = 16'd0;
                    m_valid_next    = 1'b1;
                    case (cmd)
                        CMD_INS_FIRST, CMD_INS_END, CMD_INS_AT: begin
                            if (cmd == CMD_INS_AT && pos_x > cnt_x) begin
                                res_status_next = STAT_RANGE;
                            end else if (list_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                op = CELL_INS;
                                if (cmd == CMD_INS_FIRST) begin
                                    wr_idx = '0;
                                end else if (cmd == CMD_INS_END) begin
                                    wr_idx = IDX_W'(count_reg);
                                end else begin
                                    wr_idx = IDX_W'(pos);
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REM_FIRST, CMD_REM_LAST: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                op         = CELL_DEL;
                                wr_idx     = (cmd == CMD_REM_FIRST) ? '0 : tail_idx;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_REM_ITEM: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else if (!any_hit) begin
                                res_status_next = STAT_NOT_FOUND;
                            end else begin
                                res_fpos_next = hit_idx[3:0];
                                op            = CELL_DEL;
                                wr_idx        = hit_idx;
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        CMD_REM_AT: begin
                            if (pos_x >= cnt_x) begin
                                res_status_next = STAT_RANGE;
                            end else begin
                                op         = CELL_DEL;
                                wr_idx     = IDX_W'(pos);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            if (!any_hit) begin
                                res_status_next = STAT_NOT_FOUND;
                            end else begin
                                res_fpos_next = hit_idx[3:0];
                            end
                        end
                        CMD_GET: begin
                            if (pos_x >= cnt_x) begin
                                res_status_next = STAT_RANGE;
                            end else begin
                                res_rd_next = rd_wide[15:0];
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_REVERSE: begin
                            // The result goes out now; the remaining steps run stalled.
                            if (count_reg > CW'(1)) begin
                                op     = CELL_INS;
                                wr_idx = '0;
                                if (count_reg > CW'(2)) begin
                                    state_next = ST_REV;
                                    k_next     = IW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    res_count_next = 5'(CNT_W'(count_next));
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_fpos_reg   <= res_fpos_next;
        res_rd_reg     <= res_rd_next;
        res_count_reg  <= res_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, res_count_reg, res_rd_reg, res_fpos_reg, res_status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_rev_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REV |-> count_reg > CW'(2) && CW'(k_reg) < count_reg - CW'(1))
        else $error("reverse step outside the list");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_CLEAR |=> count_reg == '0)
        else $error("clear left entries behind");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg && res_count_reg == 5'(CNT_W'(count_reg)))
        else $error("accepted item gave no matching result");

endmodule

// ----- verif/tb_ordered_handle_list.sv -----
module tb_ordered_handle_list;
    timeunit 1ns;
    timeprecision 1ps;

    import ohl_pkg::*;

    localparam int         LIST_CAP       = DEF_CAPACITY;
    localparam logic [3:0] CMD_UNKNOWN_LO = 4'd11;
    localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
    localparam int         MAX_PRINTED    = 40;

    typedef struct packed {
        status_t     status;
        logic [3:0]  found_pos;
        logic [15:0] read_hnd;
        logic [4:0]  length;
    } list_result_t;

    typedef struct {
        logic [3:0]   cmd;
        logic [4:0]   pos;
        logic [15:0]  hnd;
        int           reps;
        bit           typed;
        list_result_t want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // command[3:0], position[8:4], handle[24:9], zeros
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // status[2:0], found_position[6:3],
                                  // read_handle[22:7], count[27:23], zeros

    ordered_handle_list uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Shadow copy of the list, updated as each item is accepted.
    logic [15:0]  list_mem [LIST_CAP];
    int unsigned  list_len = 0;
    list_result_t pending_results [$];
    int           mismatch_count = 0;
    int           results_seen   = 0;
    int           send_idle_pct  = 22;
    int           recv_idle_pct  = 68;
    int           hold_request   = 0;
    int           hold_left      = 0;

    localparam list_result_t NO_RESULT = '{STAT_OK, 4'd0, 16'd0, 5'd0};

    stim_row_t directed_rows [28] = '{
        '{CMD_REM_FIRST,  5'd0,  16'h0000, 1,  1'b1, '{STAT_EMPTY, 4'd0, 16'd0, 5'd0}},
        '{CMD_REM_LAST,   5'd0,  16'h0000, 1,  1'b1, '{STAT_EMPTY, 4'd0, 16'd0, 5'd0}},
        '{CMD_REM_ITEM,   5'd0,  16'hFFFF, 1,  1'b1, '{STAT_EMPTY, 4'd0, 16'd0, 5'd0}},
        '{CMD_REM_AT,     5'd0,  16'h0000, 1,  1'b1, '{STAT_RANGE, 4'd0, 16'd0, 5'd0}},
        '{CMD_GET,        5'd0,  16'h0000, 1,  1'b1, '{STAT_RANGE, 4'd0, 16'd0, 5'd0}},
        '{CMD_SEARCH,     5'd0,  16'h0000, 1,  1'b1, '{STAT_NOT_FOUND, 4'd0, 16'd0, 5'd0}},
        '{CMD_REVERSE,    5'd0,  16'h0000, 1,  1'b1, '{STAT_OK, 4'd0, 16'd0, 5'd0}},
        '{CMD_INS_AT,     5'd1,  16'h1111, 1,  1'b1, '{STAT_RANGE, 4'd0, 16'd0, 5'd0}},
        '{CMD_INS_FIRST,  5'd0,  16'hFFFF, 1,  1'b1, '{STAT_OK, 4'd0, 16'd0, 5'd1}},
        '{CMD_REVERSE,    5'd0,  16'h0000, 1,  1'b1, '{STAT_OK, 4'd0, 16'd0, 5'd1}},
        '{CMD_GET,        5'd0,  16'h0000, 1,  1'b1, '{STAT_OK, 4'd0, 16'hFFFF, 5'd1}},
        '{CMD_INS_END,    5'd0,  16'h0000, 1,  1'b0, NO_RESULT},
        '{CMD_INS_AT,     5'd1,  16'hA5A5, 1,  1'b0, NO_RESULT},
        '{CMD_INS_AT,     5'd31, 16'h5A5A, 1,  1'b1, '{STAT_RANGE, 4'd0, 16'd0, 5'd3}},
        '{CMD_SEARCH,     5'd0,  16'hA5A5, 1,  1'b0, NO_RESULT},
        '{CMD_REM_ITEM,   5'd0,  16'h1234, 1,  1'b0, NO_RESULT},
        '{CMD_REVERSE,    5'd0,  16'h0000, 1,  1'b0, NO_RESULT},
        '{CMD_UNKNOWN_HI, 5'd31, 16'hFFFF, 1,  1'b0, NO_RESULT},
        '{CMD_CLEAR,      5'd0,  16'h0000, 1,  1'b1, '{STAT_OK, 4'd0, 16'd0, 5'd0}},
        '{CMD_GET,        5'd1,  16'h0000, 1,  1'b1, '{STAT_RANGE, 4'd0, 16'd0, 5'd0}},
        '{CMD_INS_END,    5'd0,  16'h8000, 16, 1'b0, NO_RESULT},
        '{CMD_INS_FIRST,  5'd0,  16'h8003, 1,  1'b1, '{STAT_FULL, 4'd0, 16'd0, 5'd16}},
        '{CMD_INS_AT,     5'd17, 16'h8003, 1,  1'b1, '{STAT_RANGE, 4'd0, 16'd0, 5'd16}},
        '{CMD_INS_AT,     5'd16, 16'h8003, 1,  1'b1, '{STAT_FULL, 4'd0, 16'd0, 5'd16}},
        '{CMD_SEARCH,     5'd0,  16'h800F, 1,  1'b0, NO_RESULT},
        '{CMD_REM_AT,     5'd15, 16'h0000, 1,  1'b0, NO_RESULT},
        '{CMD_INS_FIRST,  5'd0,  16'h8004, 1,  1'b0, NO_RESULT},
        '{CMD_REM_ITEM,   5'd0,  16'h8004, 1,  1'b0, NO_RESULT}
    };

    function automatic int unsigned find_handle(logic [15:0] hnd);
        for (int unsigned i = 0; i < list_len; i++) begin
            if (list_mem[i] == hnd) begin
                return i;
            end
        end
        return list_len;
    endfunction

    function automatic void drop_slot(int unsigned slot);
        for (int unsigned i = slot; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
        end
        list_len--;
    endfunction

    // Applies one command to the shadow list and returns the result it must produce.
    function automatic list_result_t list_step(logic [3:0] cmd, logic [4:0] pos,
                                               logic [15:0] hnd);
        list_result_t res;
        int unsigned  slot;
        int unsigned  lo;
        int unsigned  hi;
        logic [15:0]  tmp;
        res = NO_RESULT;
        case (cmd)
            CMD_INS_FIRST, CMD_INS_END, CMD_INS_AT: begin
                // The range check on ins_at wins over the full check.
                if (cmd == CMD_INS_AT && pos > list_len) begin
                    res.status = STAT_RANGE;
                end else if (list_len >= LIST_CAP) begin
                    res.status = STAT_FULL;
                end else begin
                    slot = (cmd == CMD_INS_FIRST) ? 0 : (cmd == CMD_INS_END) ? list_len : pos;
                    for (int unsigned i = list_len; i > slot; i--) begin
                        list_mem[i] = list_mem[i - 1];
                    end
                    list_mem[slot] = hnd;
                    list_len++;
                end
            end
            CMD_REM_FIRST, CMD_REM_LAST: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    drop_slot((cmd == CMD_REM_FIRST) ? 0 : list_len - 1);
                end
            end
            CMD_REM_ITEM: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    slot = find_handle(hnd);
                    if (slot >= list_len) begin
                        res.status = STAT_NOT_FOUND;
                    end else begin
                        res.found_pos = 4'(slot);
                        drop_slot(slot);
                    end
                end
            end
            CMD_REM_AT: begin
                if (pos >= list_len) begin
                    res.status = STAT_RANGE;
                end else begin
                    drop_slot(pos);
                end
            end
            CMD_SEARCH: begin
                slot = find_handle(hnd);
                if (slot >= list_len) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    res.found_pos = 4'(slot);
                end
            end
            CMD_GET: begin
                if (pos >= list_len) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.read_hnd = list_mem[pos];
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            CMD_REVERSE: begin
                if (list_len > 1) begin
                    lo = 0;
                    hi = list_len - 1;
                    while (lo < hi) begin
                        tmp          = list_mem[lo];
                        list_mem[lo] = list_mem[hi];
                        list_mem[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            default: begin
            end
        endcase
        res.length = 5'(list_len);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
        end
    endtask

    // Offers one item, waits for it to be taken, then records what it must return.
    task automatic send_cmd(logic [3:0] cmd, logic [4:0] pos, logic [15:0] hnd,
                            bit typed, list_result_t want);
        int           n_idle;
        list_result_t predicted;
        n_idle = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            n_idle++;
        end
        if (n_idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (n_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, hnd, pos, cmd};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = list_step(cmd, pos, hnd);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_results.size() != 0);
    endtask

    // Receiver: random stalls, plus long hold-offs requested by the stimulus.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    list_result_t got_res;
    list_result_t want_res;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 32'd0);
            end else begin
                want_res = pending_results.pop_front();
                got_res  = '{status_t'(m_tdata[2:0]), m_tdata[6:3], m_tdata[22:7],
                             m_tdata[27:23]};
                if (got_res.status !== want_res.status) begin
                    report_mismatch("status", 32'(got_res.status), 32'(want_res.status));
                end
                if (got_res.found_pos !== want_res.found_pos) begin
                    report_mismatch("found_position", 32'(got_res.found_pos),
                                    32'(want_res.found_pos));
                end
                if (got_res.read_hnd !== want_res.read_hnd) begin
                    report_mismatch("read_handle", 32'(got_res.read_hnd),
                                    32'(want_res.read_hnd));
                end
                if (got_res.length !== want_res.length) begin
                    report_mismatch("count", 32'(got_res.length), 32'(want_res.length));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [15:0] handle_pool [8];
        logic [3:0]  cmd;
        logic [4:0]  pos;
        logic [15:0] hnd;
        bit          filling;
        int          w;
        filling = 1'b1;
        for (int i = 0; i < 8; i++) begin
            handle_pool[i] = 16'($urandom());
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_cmd(directed_rows[r].cmd, directed_rows[r].pos,
                         directed_rows[r].hnd + 16'(k), directed_rows[r].typed,
                         directed_rows[r].want);
            end
        end
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 22 : 0;
            for (int n = 0; n < 640; n++) begin
                // Back up the result side so the block fills and stalls its input.
                if (phase == 2 && n == 150) begin
                    hold_request = 150;
                end
                if (phase == 1 && n == 300) begin
                    wait_drained();
                end

                // Swing between growing and shrinking so full and empty are both hit.
                if (list_len == LIST_CAP && $urandom_range(2) == 0) begin
                    filling = 1'b0;
                end else if (list_len == 0 && $urandom_range(2) == 0) begin
                    filling = 1'b1;
                end
                w = $urandom_range(99);
                if (w < 1) begin
                    cmd = CMD_CLEAR;
                end else if (w < 4) begin
                    cmd = 4'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
                end else if (w < 10) begin
                    cmd = CMD_REVERSE;
                end else if (w < 18) begin
                    cmd = CMD_SEARCH;
                end else if (w < 25) begin
                    cmd = CMD_GET;
                end else if (w < (filling ? 77 : 49)) begin
                    cmd = 4'(CMD_INS_FIRST + $urandom_range(2));
                end else begin
                    cmd = 4'(CMD_REM_FIRST + $urandom_range(3));
                end

                pos = ($urandom_range(7) == 0) ? 5'($urandom()) : 5'($urandom_range(list_len));

                w = $urandom_range(9);
                if (w < 4 && list_len != 0) begin
                    hnd = list_mem[$urandom_range(list_len - 1)];
                end else if (w < 7) begin
                    hnd = handle_pool[$urandom_range(7)];
                end else begin
                    hnd = 16'($urandom());
                end

                send_cmd(cmd, pos, hnd, 1'b0, NO_RESULT);
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ohl_pkg.sv
rtl/core/ohl_cell.sv
rtl/core/ordered_handle_list.sv
verif/tb_ordered_handle_list.sv
